FILE: sv/tmr_pkg.sv
// Package for the tile-map pixel renderer: store sizes, register map, opcodes,
// sequencer states, shared structs and the grey-level table.
// No dependencies.
package tmr_pkg;

	localparam int BANK_BYTES    = 8192;
	localparam int PALETTE_BYTES = 64;
	localparam int BANK_AW       = $clog2(BANK_BYTES);
	localparam int VRAM_DEPTH    = 2 * BANK_BYTES;
	localparam int VRAM_AW       = $clog2(VRAM_DEPTH);
	localparam int PAL_AW        = $clog2(PALETTE_BYTES);

	// APB register map, byte address = 4 * index
	localparam int CFG_AW = 5;
	localparam logic [2:0] REG_LCD_CONTROL  = 3'd0;
	localparam logic [2:0] REG_SCROLL_X     = 3'd1;
	localparam logic [2:0] REG_SCROLL_Y     = 3'd2;
	localparam logic [2:0] REG_WINDOW_X     = 3'd3;
	localparam logic [2:0] REG_WINDOW_Y     = 3'd4;
	localparam logic [2:0] REG_MONO_PALETTE = 3'd5;
	localparam logic [2:0] REG_COLOR_MODE   = 3'd6;

	localparam logic [7:0] LCD_CONTROL_RST  = 8'h91;
	localparam logic [7:0] MONO_PALETTE_RST = 8'hFC;

	// lcd_control bits
	localparam int LCD_DISPLAY_EN = 7;
	localparam int LCD_WIN_MAP    = 6;
	localparam int LCD_WIN_EN     = 5;
	localparam int LCD_TILE_MODE  = 4;
	localparam int LCD_BG_MAP     = 3;

	// attribute bits
	localparam int ATTR_PRIO  = 7;
	localparam int ATTR_YFLIP = 6;
	localparam int ATTR_XFLIP = 5;
	localparam int ATTR_BANK  = 3;

	// signed tile addressing: 0x0800 + (tile ^ 0x80) * 16, in 16-byte blocks
	localparam logic [8:0] TILE_SIGNED_BASE = 9'h080;
	localparam logic [7:0] TILE_SIGN_FLIP   = 8'h80;
	localparam logic [2:0] WIN_X_OFFSET     = 3'h7;

	typedef enum logic [1:0] {
		OP_VRAM_WR = 2'd0,
		OP_PAL_WR  = 2'd1,
		OP_RENDER  = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_ATTR,
		ST_LO,
		ST_HI,
		ST_PAL0,
		ST_PAL1,
		ST_PAL2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [7:0] lcd_control;
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;
		logic [7:0] window_x;
		logic [7:0] window_y;
		logic [7:0] mono_palette;
		logic       color_mode;
	} cfg_t;

	// operands handed from the sequencer to the shade stage
	typedef struct packed {
		logic       white;
		logic       color;
		logic       win;
		logic [1:0] idx;
		logic [7:0] attr;
		logic [7:0] pal_lo;
		logic [7:0] pal_hi;
		logic [7:0] mono_palette;
	} pix_ops_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [1:0] shade_index;
		logic       bg_priority;
		logic       from_window;
	} pix_t;

	function automatic logic [7:0] grey_of(input logic [1:0] shade);
		logic [7:0] g;
		unique case (shade)
			2'd0: g = 8'hFF;
			2'd1: g = 8'hAA;
			2'd2: g = 8'h55;
			2'd3: g = 8'h00;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

endpackage

FILE: sv/tmr_if.sv
// Valid/ready stream interfaces for the renderer's item and result channels.
// Depends on nothing; field widths follow the item and result formats.
interface tmr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic        bank;
	logic [12:0] mem_address;
	logic [7:0]  write_data;
	logic [7:0]  pixel_x;
	logic [7:0]  pixel_y;

	modport source (output valid, opcode, bank, mem_address, write_data, pixel_x, pixel_y,
		input ready);
	modport sink (input valid, opcode, bank, mem_address, write_data, pixel_x, pixel_y,
		output ready);
endinterface

interface tmr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [1:0] shade_index;
	logic       bg_priority;
	logic       from_window;

	modport source (output valid, red, green, blue, shade_index, bg_priority, from_window,
		input ready);
	modport sink (input valid, red, green, blue, shade_index, bg_priority, from_window,
		output ready);
endinterface

FILE: sv/tile_map_bg_window_pixel_renderer.sv
// Top level of the tile-map background/window pixel renderer, 2 bits per pixel.
// Depends on tmr_pkg, tmr_if, tmr_ram, tmr_regs, tmr_shade and tmr_seq.
//
// Items arrive on pix_in: opcode 0 writes a video byte (bank, mem_address),
// opcode 1 writes a palette byte (low six address bits), opcode 2 renders the
// pixel at (pixel_x, pixel_y) and sends one beat on pix_out; opcode 3 is dropped.
// Write items are taken one per cycle. A render holds the input off while it
// runs. Its length comes from the single port of the video store, which serves
// the map, attribute, low plane and high plane reads one after the other, and
// in colour mode from the palette store, which serves the two colour bytes.
// With the display off no store is read. The finished pixel sits in an output
// register, so the next item may be accepted while the last beat is still
// waiting. Both stores power up undefined and are not cleared; render only
// what was written.
// Configuration goes through the APB port at byte address 4*index and should
// only be changed while no render is in flight.

module tile_map_bg_window_pixel_renderer
	import tmr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	tmr_in_if.sink            pix_in,
	tmr_out_if.source         pix_out
);

	cfg_t cfg;

	// store ports, driven by the sequencer
	logic               vram_we, pal_we;
	logic [VRAM_AW-1:0] vram_addr;
	logic [PAL_AW-1:0]  pal_addr;
	logic [7:0]         vram_wdata, vram_rdata, pal_wdata, pal_rdata;

	pix_ops_t ops;
	pix_t     pix;

	tmr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// two banks back to back: bank 0 holds maps and tiles, bank 1 attributes and tiles
	tmr_ram #(
		.WIDTH (8),
		.DEPTH (VRAM_DEPTH)
	) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.addr  (vram_addr),
		.wdata (vram_wdata),
		.rdata (vram_rdata)
	);

	// colour palettes, two bytes per colour, low byte first
	tmr_ram #(
		.WIDTH (8),
		.DEPTH (PALETTE_BYTES)
	) u_pal (
		.clk   (clk),
		.we    (pal_we),
		.addr  (pal_addr),
		.wdata (pal_wdata),
		.rdata (pal_rdata)
	);

	tmr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pix_in     (pix_in),
		.pix_out    (pix_out),
		.vram_we    (vram_we),
		.vram_addr  (vram_addr),
		.vram_wdata (vram_wdata),
		.vram_rdata (vram_rdata),
		.pal_we     (pal_we),
		.pal_addr   (pal_addr),
		.pal_wdata  (pal_wdata),
		.pal_rdata  (pal_rdata),
		.ops        (ops),
		.pix        (pix)
	);

	// shade lookup sits in front of the output register
	tmr_shade u_shade (
		.ops (ops),
		.pix (pix)
	);

endmodule

FILE: sv/tmr_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
module tmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: sv/tmr_regs.sv
// APB configuration registers of the renderer.
// Depends on tmr_pkg.
module tmr_regs
	import tmr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[CFG_AW-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lcd_control  <= LCD_CONTROL_RST;
			cfg_q.scroll_x     <= '0;
			cfg_q.scroll_y     <= '0;
			cfg_q.window_x     <= '0;
			cfg_q.window_y     <= '0;
			cfg_q.mono_palette <= MONO_PALETTE_RST;
			cfg_q.color_mode   <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_LCD_CONTROL:  cfg_q.lcd_control  <= pwdata[7:0];
				REG_SCROLL_X:     cfg_q.scroll_x     <= pwdata[7:0];
				REG_SCROLL_Y:     cfg_q.scroll_y     <= pwdata[7:0];
				REG_WINDOW_X:     cfg_q.window_x     <= pwdata[7:0];
				REG_WINDOW_Y:     cfg_q.window_y     <= pwdata[7:0];
				REG_MONO_PALETTE: cfg_q.mono_palette <= pwdata[7:0];
				REG_COLOR_MODE:   cfg_q.color_mode   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_LCD_CONTROL:  prdata = {24'h0, cfg_q.lcd_control};
			REG_SCROLL_X:     prdata = {24'h0, cfg_q.scroll_x};
			REG_SCROLL_Y:     prdata = {24'h0, cfg_q.scroll_y};
			REG_WINDOW_X:     prdata = {24'h0, cfg_q.window_x};
			REG_WINDOW_Y:     prdata = {24'h0, cfg_q.window_y};
			REG_MONO_PALETTE: prdata = {24'h0, cfg_q.mono_palette};
			REG_COLOR_MODE:   prdata = {31'h0, cfg_q.color_mode};
			default:          prdata = 32'h0;
		endcase
	end

endmodule

FILE: sv/tmr_shade.sv
// Final colour stage: mono shade through the palette register, or a 15-bit
// colour word split into 8-bit channels. Depends on tmr_pkg.
module tmr_shade
	import tmr_pkg::*;
(
	input  pix_ops_t ops,
	output pix_t     pix
);

	logic [15:0] cw;
	logic [1:0]  shade;

	assign cw = {ops.pal_hi, ops.pal_lo};

	always_comb begin
		unique case (ops.idx)
			2'd0: shade = ops.mono_palette[1:0];
			2'd1: shade = ops.mono_palette[3:2];
			2'd2: shade = ops.mono_palette[5:4];
			2'd3: shade = ops.mono_palette[7:6];
			default: shade = 2'd0;
		endcase
	end

	always_comb begin
		priority if (ops.white) begin
			pix.red         = 8'hFF;
			pix.green       = 8'hFF;
			pix.blue        = 8'hFF;
			pix.shade_index = 2'd0;
			pix.bg_priority = 1'b0;
			pix.from_window = 1'b0;
		end else if (ops.color) begin
			pix.red         = {cw[4:0], 3'b000};
			pix.green       = {cw[9:5], 3'b000};
			pix.blue        = {cw[14:10], 3'b000};
			pix.shade_index = ops.idx;
			pix.bg_priority = ops.attr[ATTR_PRIO];
			pix.from_window = ops.win;
		end else begin
			pix.red         = grey_of(shade);
			pix.green       = grey_of(shade);
			pix.blue        = grey_of(shade);
			pix.shade_index = shade;
			pix.bg_priority = 1'b0;
			pix.from_window = ops.win;
		end
	end

endmodule

FILE: sv/tmr_seq.sv
// Render sequencer: steps one address unit through the map, attribute, tile row
// and palette reads, and holds the result beat. Depends on tmr_pkg, tmr_if.
module tmr_seq
	import tmr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	tmr_in_if.sink              pix_in,
	tmr_out_if.source           pix_out,
	// video store port
	output logic                vram_we,
	output logic [VRAM_AW-1:0]  vram_addr,
	output logic [7:0]          vram_wdata,
	input  logic [7:0]          vram_rdata,
	// palette store port
	output logic                pal_we,
	output logic [PAL_AW-1:0]   pal_addr,
	output logic [7:0]          pal_wdata,
	input  logic [7:0]          pal_rdata,
	// shade stage
	output pix_ops_t            ops,
	input  pix_t                pix
);

	state_t state_q, state_d;

	logic       accept, load_out;
	logic       out_valid_q;
	pix_t       out_q;

	logic       white_q, win_q, map_sel_q;
	logic [7:0] lx_q, ly_q;
	logic [7:0] tile_q, attr_q, lo_q, clo_q, chi_q;
	logic [1:0] idx_q;
	logic [BANK_AW-1:0] tline_q;

	// coordinate setup at accept
	logic       win_hit;
	logic [8:0] px_ext;
	logic [7:0] lx_d, ly_d;

	// address unit
	logic [BANK_AW-1:0] ent;
	logic [7:0]         attr_d;
	logic [8:0]         tile_blk;
	logic [2:0]         row, col;
	logic [1:0]         idx_d;

	assign accept = pix_in.valid && pix_in.ready;

	assign px_ext  = {1'b0, pix_in.pixel_x} + {6'b0, WIN_X_OFFSET};
	assign win_hit = cfg.lcd_control[LCD_WIN_EN] && (cfg.window_y <= pix_in.pixel_y)
		&& (px_ext >= {1'b0, cfg.window_x});

	always_comb begin
		if (win_hit) begin
			lx_d = px_ext[7:0] - cfg.window_x;
			ly_d = pix_in.pixel_y - cfg.window_y;
		end else begin
			lx_d = pix_in.pixel_x + cfg.scroll_x;
			ly_d = pix_in.pixel_y + cfg.scroll_y;
		end
	end

	// map base 0x1800 or 0x1C00, then row of 32 entries, then column
	assign ent = {2'b11, map_sel_q, ly_q[7:3], lx_q[7:3]};

	// in ST_LO the read data is the attribute byte
	assign attr_d = cfg.color_mode ? vram_rdata : 8'h00;
	assign tile_blk = cfg.lcd_control[LCD_TILE_MODE] ? {1'b0, tile_q}
		: TILE_SIGNED_BASE + {1'b0, tile_q ^ TILE_SIGN_FLIP};
	assign row = ly_q[2:0] ^ {3{attr_d[ATTR_YFLIP]}};
	// in ST_PAL0 the read data is the high plane byte
	assign col = lx_q[2:0] ^ {3{attr_q[ATTR_XFLIP]}};
	assign idx_d = {vram_rdata[3'd7 - col], lo_q[3'd7 - col]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && pix_in.opcode == OP_RENDER) begin
					state_d = cfg.lcd_control[LCD_DISPLAY_EN] ? ST_MAP : ST_DONE;
				end
			end
			ST_MAP:  state_d = ST_ATTR;
			ST_ATTR: state_d = ST_LO;
			ST_LO:   state_d = ST_HI;
			ST_HI:   state_d = ST_PAL0;
			ST_PAL0: state_d = cfg.color_mode ? ST_PAL1 : ST_DONE;
			ST_PAL1: state_d = ST_PAL2;
			ST_PAL2: state_d = ST_DONE;
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and store ports
	always_comb begin
		pix_in.ready = 1'b0;
		load_out     = 1'b0;
		vram_we      = 1'b0;
		pal_we       = 1'b0;
		vram_wdata   = pix_in.write_data;
		pal_wdata    = pix_in.write_data;
		vram_addr    = {tline_q, 1'b1};
		pal_addr     = {attr_q[2:0], idx_q, 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				pix_in.ready = 1'b1;
				vram_addr    = {pix_in.bank, pix_in.mem_address};
				pal_addr     = pix_in.mem_address[PAL_AW-1:0];
				vram_we      = pix_in.valid && pix_in.opcode == OP_VRAM_WR;
				pal_we       = pix_in.valid && pix_in.opcode == OP_PAL_WR;
			end
			ST_MAP:  vram_addr = {1'b0, ent};
			ST_ATTR: vram_addr = {1'b1, ent};
			ST_LO:   vram_addr = {attr_d[ATTR_BANK], tile_blk, row, 1'b0};
			ST_HI:   vram_addr = {tline_q, 1'b1};
			ST_PAL0: pal_addr  = {attr_q[2:0], idx_d, 1'b0};
			ST_PAL1: pal_addr  = {attr_q[2:0], idx_q, 1'b1};
			ST_PAL2: ;
			ST_DONE: load_out  = !out_valid_q || pix_out.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			white_q   <= !cfg.lcd_control[LCD_DISPLAY_EN];
			win_q     <= win_hit && cfg.lcd_control[LCD_DISPLAY_EN];
			map_sel_q <= win_hit ? cfg.lcd_control[LCD_WIN_MAP] : cfg.lcd_control[LCD_BG_MAP];
			lx_q      <= lx_d;
			ly_q      <= ly_d;
		end
		if (state_q == ST_ATTR) begin
			tile_q <= vram_rdata;
		end
		if (state_q == ST_LO) begin
			attr_q  <= attr_d;
			tline_q <= {attr_d[ATTR_BANK], tile_blk, row};
		end
		if (state_q == ST_HI) begin
			lo_q <= vram_rdata;
		end
		if (state_q == ST_PAL0) begin
			idx_q <= idx_d;
		end
		if (state_q == ST_PAL1) begin
			clo_q <= pal_rdata;
		end
		if (state_q == ST_PAL2) begin
			chi_q <= pal_rdata;
		end
		if (load_out) begin
			out_q <= pix;
		end
	end

	assign ops.white        = white_q;
	assign ops.color        = cfg.color_mode;
	assign ops.win          = win_q;
	assign ops.idx          = idx_q;
	assign ops.attr         = attr_q;
	assign ops.pal_lo       = clo_q;
	assign ops.pal_hi       = chi_q;
	assign ops.mono_palette = cfg.mono_palette;

	assign pix_out.valid       = out_valid_q;
	assign pix_out.red         = out_q.red;
	assign pix_out.green       = out_q.green;
	assign pix_out.blue        = out_q.blue;
	assign pix_out.shade_index = out_q.shade_index;
	assign pix_out.bg_priority = out_q.bg_priority;
	assign pix_out.from_window = out_q.from_window;

endmodule
